// ----- rtl/core/mrc_pkg.sv -----
// mrc_pkg: shared types, codes and limits of the request checker
// no dependencies; imported by mrc_decode, mrc_state and the top level
package mrc_pkg;

    // default sizes handed to the top level parameters
    localparam int BUFFER_BYTES_DEF  = 64;
    localparam int COUNTER_COUNT_DEF = 10;

    // diagnostic counter indexes
    localparam int IX_BUS_MSG   = 1;
    localparam int IX_EXCEPTION = 3;
    localparam int IX_SLAVE_MSG = 4;
    localparam int IX_NO_RESP   = 5;
    localparam int IX_NAK       = 6;
    localparam int IX_BUSY      = 7;
    localparam int IX_OVERRUN   = 8;
    localparam int IX_FC11      = 9;

    // function codes
    localparam logic [7:0] FC_READ_COILS      = 8'd1;
    localparam logic [7:0] FC_READ_INPUTS     = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
    localparam logic [7:0] FC_READ_INPUT_REGS = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
    localparam logic [7:0] FC_WRITE_REG       = 8'd6;
    localparam logic [7:0] FC_READ_EXC_STATUS = 8'd7;
    localparam logic [7:0] FC_DIAGNOSTIC      = 8'd8;
    localparam logic [7:0] FC_EVENT_COUNTER   = 8'd11;
    localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS      = 8'd16;
    localparam logic [7:0] FC_READ_WRITE_REGS = 8'd23;

    // diagnostic subfunctions
    localparam logic [15:0] SF_RETURN_QUERY   = 16'h0000;
    localparam logic [15:0] SF_RESTART        = 16'h0001;
    localparam logic [15:0] SF_FORCE_LISTEN   = 16'h0004;
    localparam logic [15:0] SF_CLEAR_COUNTERS = 16'h000A;
    localparam logic [15:0] SF_FIRST_COUNT    = 16'h000B;
    localparam logic [15:0] SF_LAST_COUNT     = 16'h0012;
    localparam logic [15:0] SF_CLEAR_OVERRUN  = 16'h0014;

    // exception codes
    localparam logic [7:0] EX_NONE             = 8'd0;
    localparam logic [7:0] EX_ILLEGAL_FUNCTION = 8'd1;
    localparam logic [7:0] EX_ILLEGAL_VALUE    = 8'd3;
    localparam logic [7:0] EX_SLAVE_BUSY       = 8'd6;
    localparam logic [7:0] EX_NAK              = 8'd7;

    // request field limits
    localparam logic [15:0] MAX_READ_BITS   = 16'd2000;
    localparam logic [15:0] MAX_READ_REGS   = 16'd125;
    localparam logic [15:0] MAX_WRITE_BITS  = 16'h07B0;
    localparam logic [15:0] MAX_WRITE_REGS  = 16'h007B;
    localparam logic [15:0] MAX_RW_READ     = 16'h007D;
    localparam logic [15:0] MAX_RW_WRITE    = 16'h0079;
    localparam logic [15:0] COIL_ON         = 16'hFF00;
    localparam logic [7:0]  EXC_FLAG        = 8'h80;
    localparam logic [7:0]  MAX_SLAVE_ADDR  = 8'd247;
    localparam logic [7:0]  RESET_SLAVE_ADDR = 8'd1;
    localparam logic [15:0] STATUS_BUSY     = 16'hFFFF;

    typedef enum logic [1:0] {
        RK_NONE      = 2'd0,
        RK_NORMAL    = 2'd1,
        RK_EXCEPTION = 2'd2
    } t_reply_kind;

    typedef enum logic [2:0] {
        OC_OTHER     = 3'd0,
        OC_DONE      = 3'd1,
        OC_EXCEPTION = 3'd2,
        OC_SILENT    = 3'd3,
        OC_RESTART   = 3'd4
    } t_outcome;

    // registered request header
    typedef struct packed {
        logic [7:0]  frame_length;
        logic [7:0]  unit_id;
        logic [7:0]  function_code;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [7:0]  byte_count;
        logic [15:0] word_d;
        logic [7:0]  byte_ten;
        logic        store_busy;
        logic [7:0]  store_status;
    } t_request;

    // one reply decision
    typedef struct packed {
        t_reply_kind reply_kind;
        logic [7:0]  reply_length;
        logic [7:0]  reply_function;
        logic [7:0]  exception_code;
        logic [15:0] reply_word;
        logic [15:0] status_word;
        logic        store_access;
        logic        restart_request;
        logic        flush_request;
        t_outcome    outcome;
    } t_result;

    // state changes caused by one request
    typedef struct packed {
        logic bump_bus;
        logic bump_slave;
        logic bump_no_resp;
        logic bump_exception;
        logic bump_nak;
        logic bump_busy;
        logic bump_fc11;
        logic clear_all;
        logic clear_overrun;
        logic set_listen;
    } t_state_upd;

endpackage

// ----- rtl/core/mrc_state.sv -----
// mrc_state: diagnostic counter file and listen-only flag
// depends on mrc_pkg for counter indexes and the update struct
module mrc_state #(
    parameter int COUNTER_COUNT = mrc_pkg::COUNTER_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_upd_en,
    input  mrc_pkg::t_state_upd  i_upd,
    output logic                 o_listen_only,
    output logic [15:0]          o_diag [mrc_pkg::IX_FC11:1]
);
    import mrc_pkg::*;

    logic [15:0] r_cnt [COUNTER_COUNT];
    logic [15:0] n_cnt [COUNTER_COUNT];
    logic        r_listen;
    logic        n_listen;

    always_comb begin
        logic inc;
        for (int i = 0; i < COUNTER_COUNT; i++) begin
            inc = (i == IX_BUS_MSG   && i_upd.bump_bus)       ||
                  (i == IX_SLAVE_MSG && i_upd.bump_slave)     ||
                  (i == IX_NO_RESP   && i_upd.bump_no_resp)   ||
                  (i == IX_EXCEPTION && i_upd.bump_exception) ||
                  (i == IX_NAK       && i_upd.bump_nak)       ||
                  (i == IX_BUSY      && i_upd.bump_busy)      ||
                  (i == IX_FC11      && i_upd.bump_fc11);
            n_cnt[i] = r_cnt[i];
            if (i_upd_en) begin
                if (i_upd.clear_all || (i == IX_OVERRUN && i_upd.clear_overrun)) begin
                    n_cnt[i] = '0;
                end else begin
                    n_cnt[i] = r_cnt[i] + 16'(inc);
                end
            end
        end
        n_listen = r_listen | (i_upd_en & i_upd.set_listen);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < COUNTER_COUNT; i++) begin
                r_cnt[i] <= '0;
            end
            r_listen <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_listen <= n_listen;
        end
    end

    always_comb begin
        for (int k = 1; k <= IX_FC11; k++) begin
            o_diag[k] = r_cnt[k];
        end
    end

    assign o_listen_only = r_listen;

endmodule

// ----- rtl/core/mrc_decode.sv -----
// mrc_decode: single-pass request validation and reply selection
// depends on mrc_pkg for codes, limits and the request/result structs
module mrc_decode #(
    parameter int BUFFER_BYTES = mrc_pkg::BUFFER_BYTES_DEF
) (
    input  mrc_pkg::t_request   i_req,
    input  logic [7:0]          i_slave_address,
    input  logic                i_listen_only,
    input  logic [15:0]         i_diag [mrc_pkg::IX_FC11:1],
    output mrc_pkg::t_result    o_res,
    output mrc_pkg::t_state_upd o_upd
);
    import mrc_pkg::*;

    localparam logic [8:0]  BUF9  = 9'(BUFFER_BYTES);
    localparam logic [17:0] BUF18 = 18'(BUFFER_BYTES);

    logic [7:0]  len;
    logic [15:0] wa;
    logic [15:0] wb;
    logic [15:0] wd;
    logic        len_bad;
    logic [16:0] bits_plus7;
    logic [17:0] rlen_bits;
    logic [17:0] rlen_regs;
    logic [13:0] coil_bytes;
    logic [16:0] wb_x2;
    logic [16:0] wd_x2;
    logic [15:0] view [8];
    logic [4:0]  sel_raw;
    logic [2:0]  sel;
    logic [15:0] event_count;

    assign len        = i_req.frame_length;
    assign wa         = i_req.word_a;
    assign wb         = i_req.word_b;
    assign wd         = i_req.word_d;
    assign len_bad    = (len < 8'd2) || ({1'b0, len} > BUF9);
    assign bits_plus7 = {1'b0, wb} + 17'd7;
    assign coil_bytes = bits_plus7[16:3];
    assign rlen_bits  = 18'(coil_bytes) + 18'd3;
    assign wb_x2      = {wb, 1'b0};
    assign wd_x2      = {wd, 1'b0};
    assign rlen_regs  = {1'b0, wb_x2} + 18'd3;
    assign sel_raw    = wa[4:0] - SF_FIRST_COUNT[4:0];
    assign sel        = sel_raw[2:0];

    // counter reads see this request's bus and slave message counts
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            view[j] = i_diag[j + 1] + 16'(((j + 1) == IX_BUS_MSG) || ((j + 1) == IX_SLAVE_MSG));
        end
    end

    // the slave message and code 11 bumps of this request cancel out
    assign event_count = i_diag[IX_SLAVE_MSG] - i_diag[IX_EXCEPTION]
                       - i_diag[IX_NO_RESP] - i_diag[IX_FC11];

    always_comb begin
        logic [7:0]  exc;
        logic [17:0] rlen;
        logic        access;
        logic        silent;
        logic        restart;
        logic        flush;
        logic [15:0] word;
        logic [15:0] status;
        logic [7:0]  fc;

        o_res   = '0;
        o_upd   = '0;
        exc     = EX_NONE;
        rlen    = 18'(len);
        access  = 1'b0;
        silent  = 1'b0;
        restart = 1'b0;
        flush   = 1'b0;
        word    = '0;
        status  = '0;
        fc      = i_req.function_code;

        if (!len_bad) begin
            o_upd.bump_bus = 1'b1;
            if (i_req.unit_id == i_slave_address) begin
                o_upd.bump_slave = 1'b1;
                if (i_listen_only && !(fc == FC_DIAGNOSTIC && len >= 8'd6 && wa == SF_RESTART)) begin
                    o_upd.bump_no_resp = 1'b1;
                    o_res.outcome      = OC_SILENT;
                end else begin
                    case (fc)
                        FC_READ_COILS, FC_READ_INPUTS: begin
                            rlen = rlen_bits;
                            if (len != 8'd6 || wb == 16'd0 || wb > MAX_READ_BITS ||
                                rlen_bits + 18'd2 > BUF18) begin
                                exc = EX_ILLEGAL_VALUE;
                            end else begin
                                access = 1'b1;
                            end
                        end
                        FC_READ_HOLDING, FC_READ_INPUT_REGS: begin
                            rlen = rlen_regs;
                            if (len != 8'd6 || wb == 16'd0 || wb > MAX_READ_REGS ||
                                rlen_regs + 18'd2 > BUF18) begin
                                exc = EX_ILLEGAL_VALUE;
                            end else begin
                                access = 1'b1;
                            end
                        end
                        FC_WRITE_COIL: begin
                            rlen = 18'd6;
                            if (len != 8'd6 || (wb != 16'd0 && wb != COIL_ON)) begin
                                exc = EX_ILLEGAL_VALUE;
                            end else begin
                                access = 1'b1;
                            end
                        end
                        FC_WRITE_REG: begin
                            rlen = 18'd6;
                            if (len != 8'd6) begin
                                exc = EX_ILLEGAL_VALUE;
                            end else begin
                                access = 1'b1;
                            end
                        end
                        FC_READ_EXC_STATUS: begin
                            rlen = 18'd3;
                            if (len != 8'd2) begin
                                exc = EX_ILLEGAL_VALUE;
                            end else begin
                                access = 1'b1;
                            end
                        end
                        FC_DIAGNOSTIC: begin
                            if (len < 8'd6) begin
                                exc = EX_ILLEGAL_VALUE;
                            end else if (wa == SF_RESTART) begin
                                restart = 1'b1;
                            end else if (wa == SF_RETURN_QUERY) begin
                                // echo only
                            end else if (wa == SF_FORCE_LISTEN) begin
                                o_upd.set_listen = 1'b1;
                                silent           = 1'b1;
                            end else if (wa == SF_CLEAR_COUNTERS) begin
                                o_upd.clear_all = 1'b1;
                            end else if (wa >= SF_FIRST_COUNT && wa <= SF_LAST_COUNT) begin
                                word = view[sel];
                            end else if (wa == SF_CLEAR_OVERRUN) begin
                                o_upd.clear_overrun = 1'b1;
                                flush               = 1'b1;
                            end else begin
                                exc = EX_ILLEGAL_FUNCTION;
                            end
                        end
                        FC_EVENT_COUNTER: begin
                            rlen = 18'd6;
                            if (len != 8'd2) begin
                                exc = EX_ILLEGAL_VALUE;
                            end else begin
                                status          = i_req.store_busy ? STATUS_BUSY : 16'd0;
                                o_upd.bump_fc11 = 1'b1;
                                word            = event_count;
                            end
                        end
                        FC_WRITE_COILS: begin
                            rlen = 18'd6;
                            if (len < 8'd8 || wb == 16'd0 || wb > MAX_WRITE_BITS ||
                                14'(i_req.byte_count) != coil_bytes ||
                                {1'b0, len} != {1'b0, i_req.byte_count} + 9'd7) begin
                                exc = EX_ILLEGAL_VALUE;
                            end else begin
                                access = 1'b1;
                            end
                        end
                        FC_WRITE_REGS: begin
                            rlen = 18'd6;
                            if (len < 8'd9 || wb == 16'd0 || wb > MAX_WRITE_REGS ||
                                17'(i_req.byte_count) != wb_x2 ||
                                {1'b0, len} != {1'b0, i_req.byte_count} + 9'd7) begin
                                exc = EX_ILLEGAL_VALUE;
                            end else begin
                                access = 1'b1;
                            end
                        end
                        FC_READ_WRITE_REGS: begin
                            rlen = rlen_regs;
                            if (len < 8'd13 || wb == 16'd0 || wb > MAX_RW_READ ||
                                wd == 16'd0 || wd > MAX_RW_WRITE ||
                                17'(i_req.byte_ten) != wd_x2 ||
                                {1'b0, len} != {1'b0, i_req.byte_ten} + 9'd11 ||
                                rlen_regs + 18'd2 > BUF18) begin
                                exc = EX_ILLEGAL_VALUE;
                            end else begin
                                access = 1'b1;
                            end
                        end
                        default: begin
                            exc = EX_ILLEGAL_FUNCTION;
                        end
                    endcase

                    if (access && i_req.store_status != EX_NONE) begin
                        exc = i_req.store_status;
                    end
                    o_res.store_access = access;

                    if (restart) begin
                        // echo unless listen-only; environment resets the block
                        if (!i_listen_only) begin
                            o_res.reply_kind     = RK_NORMAL;
                            o_res.reply_length   = len;
                            o_res.reply_function = FC_DIAGNOSTIC;
                        end
                        o_res.restart_request = 1'b1;
                        o_res.outcome         = OC_RESTART;
                    end else if (silent) begin
                        o_upd.bump_no_resp = 1'b1;
                        o_res.outcome      = OC_SILENT;
                    end else if (exc != EX_NONE) begin
                        o_upd.bump_exception = 1'b1;
                        o_upd.bump_nak       = (exc == EX_NAK);
                        o_upd.bump_busy      = (exc == EX_SLAVE_BUSY);
                        o_res.reply_kind     = RK_EXCEPTION;
                        o_res.reply_length   = 8'd3;
                        o_res.reply_function = fc + EXC_FLAG;
                        o_res.exception_code = exc;
                        o_res.outcome        = OC_EXCEPTION;
                    end else begin
                        o_res.reply_kind     = RK_NORMAL;
                        o_res.reply_length   = rlen[7:0];
                        o_res.reply_function = fc;
                        o_res.reply_word     = word;
                        o_res.status_word    = status;
                        o_res.flush_request  = flush;
                        o_res.outcome        = OC_DONE;
                    end
                end
            end
        end
    end

endmodule

// ----- rtl/core/modbus_request_checker_top.sv -----
// modbus_request_checker_top: request header checker with diagnostic counters
// a request's reply decision is registered in the reply register when the held request advances
// throughput: one request per cycle while the reply side does not stall, set by the single decode pass
// between the request register and the reply register
// reset (i_rst_n low, synchronous): counters and listen-only cleared,
// slave address back to 1, both pipeline registers empty
module modbus_request_checker_top #(
    parameter int BUFFER_BYTES  = mrc_pkg::BUFFER_BYTES_DEF,
    parameter int COUNTER_COUNT = mrc_pkg::COUNTER_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: slave address
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    // request channel
    input  logic        i_req_valid,
    output logic        o_req_stall,
    input  logic [7:0]  i_frame_length,
    input  logic [7:0]  i_unit_id,
    input  logic [7:0]  i_function_code,
    input  logic [15:0] i_word_a,
    input  logic [15:0] i_word_b,
    input  logic [15:0] i_word_c,
    input  logic [15:0] i_word_d,
    input  logic [7:0]  i_byte_ten,
    input  logic        i_store_busy,
    input  logic [7:0]  i_store_status,
    // reply channel
    output logic        o_rsp_valid,
    input  logic        i_rsp_stall,
    output logic [1:0]  o_reply_kind,
    output logic [7:0]  o_reply_length,
    output logic [7:0]  o_reply_function,
    output logic [7:0]  o_exception_code,
    output logic [15:0] o_reply_word,
    output logic [15:0] o_status_word,
    output logic        o_store_access,
    output logic        o_restart_request,
    output logic        o_flush_request,
    output logic [2:0]  o_outcome
);
    import mrc_pkg::*;

    // slave address register, bad values are ignored
    logic [7:0] r_slave_address;
    logic [7:0] n_slave_address;

    // request register and reply register with their valid flags
    t_request   r_req;
    t_request   n_req;
    logic       r_req_valid;
    logic       n_req_valid;
    t_result    r_rsp;
    t_result    n_rsp;
    logic       r_rsp_valid;
    logic       n_rsp_valid;

    // decode results and state
    t_result    dec_res;
    t_state_upd dec_upd;
    logic       listen_only;
    logic [15:0] diag [IX_FC11:1];

    logic       advance;
    logic       req_take;

    // a held request moves on when the reply register is empty or draining
    assign advance     = r_req_valid && (!r_rsp_valid || !i_rsp_stall);
    assign o_req_stall = r_req_valid && !advance;
    assign req_take    = i_req_valid && !o_req_stall;

    always_comb begin
        n_slave_address = r_slave_address;
        if (i_cfg_wr_en && i_cfg_wr_data != 8'd0 && i_cfg_wr_data <= MAX_SLAVE_ADDR) begin
            n_slave_address = i_cfg_wr_data;
        end

        n_req       = r_req;
        n_req_valid = r_req_valid;
        if (req_take) begin
            n_req.frame_length  = i_frame_length;
            n_req.unit_id       = i_unit_id;
            n_req.function_code = i_function_code;
            n_req.word_a        = i_word_a;
            n_req.word_b        = i_word_b;
            // only the byte count half of word_c is ever looked at
            n_req.byte_count    = i_word_c[15:8];
            n_req.word_d        = i_word_d;
            n_req.byte_ten      = i_byte_ten;
            n_req.store_busy    = i_store_busy;
            n_req.store_status  = i_store_status;
            n_req_valid         = 1'b1;
        end else if (advance) begin
            n_req_valid = 1'b0;
        end

        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid;
        if (advance) begin
            n_rsp       = dec_res;
            n_rsp_valid = 1'b1;
        end else if (!i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= RESET_SLAVE_ADDR;
            r_req_valid     <= 1'b0;
            r_rsp_valid     <= 1'b0;
        end else begin
            r_slave_address <= n_slave_address;
            r_req_valid     <= n_req_valid;
            r_rsp_valid     <= n_rsp_valid;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_rsp <= n_rsp;
    end

    mrc_decode #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_decode (
        .i_req           (r_req),
        .i_slave_address (r_slave_address),
        .i_listen_only   (listen_only),
        .i_diag          (diag),
        .o_res           (dec_res),
        .o_upd           (dec_upd)
    );

    // counters change exactly when the decoded request is handed on
    mrc_state #(
        .COUNTER_COUNT (COUNTER_COUNT)
    ) u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_upd_en      (advance),
        .i_upd         (dec_upd),
        .o_listen_only (listen_only),
        .o_diag        (diag)
    );

    assign o_rsp_valid       = r_rsp_valid;
    assign o_reply_kind      = r_rsp.reply_kind;
    assign o_reply_length    = r_rsp.reply_length;
    assign o_reply_function  = r_rsp.reply_function;
    assign o_exception_code  = r_rsp.exception_code;
    assign o_reply_word      = r_rsp.reply_word;
    assign o_status_word     = r_rsp.status_word;
    assign o_store_access    = r_rsp.store_access;
    assign o_restart_request = r_rsp.restart_request;
    assign o_flush_request   = r_rsp.flush_request;
    assign o_outcome         = r_rsp.outcome;

endmodule

// ----- tb/modbus_request_checker_top_tb.sv -----
// modbus_request_checker_top_tb: self-checking bench for the request checker
// predicts each reply decision from its own model of counters, listen-only flag
// and slave address; depends only on mrc_pkg and modbus_request_checker_top
`timescale 1ns / 1ps

module modbus_request_checker_top_tb;
    import mrc_pkg::*;

    localparam int FRAME_BYTES      = BUFFER_BYTES_DEF;
    localparam int CLK_PERIOD       = 20;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int SETTLE_CYCLES    = 8;
    localparam int TIMEOUT_CYCLES   = 100_000;
    localparam int MAX_REPORTS      = 10;

    // one request header as the bench builds it
    typedef struct packed {
        logic [7:0]  frame_length;
        logic [7:0]  unit_id;
        logic [7:0]  function_code;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] word_c;
        logic [15:0] word_d;
        logic [7:0]  byte_ten;
        logic        store_busy;
        logic [7:0]  store_status;
    } t_bench_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;
    logic        i_req_valid;
    logic        o_req_stall;
    logic [7:0]  i_frame_length;
    logic [7:0]  i_unit_id;
    logic [7:0]  i_function_code;
    logic [15:0] i_word_a;
    logic [15:0] i_word_b;
    logic [15:0] i_word_c;
    logic [15:0] i_word_d;
    logic [7:0]  i_byte_ten;
    logic        i_store_busy;
    logic [7:0]  i_store_status;
    logic        o_rsp_valid;
    logic        i_rsp_stall;
    logic [1:0]  o_reply_kind;
    logic [7:0]  o_reply_length;
    logic [7:0]  o_reply_function;
    logic [7:0]  o_exception_code;
    logic [15:0] o_reply_word;
    logic [15:0] o_status_word;
    logic        o_store_access;
    logic        o_restart_request;
    logic        o_flush_request;
    logic [2:0]  o_outcome;

    // bench copy of the block state
    logic [15:0] diag_count [COUNTER_COUNT_DEF];
    logic        listen_mode;
    logic [7:0]  slave_addr;

    t_result     pending_replies [$];
    t_result     front_reply;
    int          mismatch_count = 0;
    int          replies_seen = 0;

    // idle percentages per side, and the one-shot long reply hold
    int          send_idle_pct;
    int          rsp_idle_pct;
    logic        long_hold_pending = 1'b0;

    modbus_request_checker_top #(
        .BUFFER_BYTES  (FRAME_BYTES),
        .COUNTER_COUNT (COUNTER_COUNT_DEF)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_req_valid       (i_req_valid),
        .o_req_stall       (o_req_stall),
        .i_frame_length    (i_frame_length),
        .i_unit_id         (i_unit_id),
        .i_function_code   (i_function_code),
        .i_word_a          (i_word_a),
        .i_word_b          (i_word_b),
        .i_word_c          (i_word_c),
        .i_word_d          (i_word_d),
        .i_byte_ten        (i_byte_ten),
        .i_store_busy      (i_store_busy),
        .i_store_status    (i_store_status),
        .o_rsp_valid       (o_rsp_valid),
        .i_rsp_stall       (i_rsp_stall),
        .o_reply_kind      (o_reply_kind),
        .o_reply_length    (o_reply_length),
        .o_reply_function  (o_reply_function),
        .o_exception_code  (o_exception_code),
        .o_reply_word      (o_reply_word),
        .o_status_word     (o_status_word),
        .o_store_access    (o_store_access),
        .o_restart_request (o_restart_request),
        .o_flush_request   (o_flush_request),
        .o_outcome         (o_outcome)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // reply decision for one accepted request; updates the bench state
    task automatic predict_reply(input t_bench_req r, output t_result res);
        int unsigned len, wb, nc, wd, n10, rlen;
        logic [7:0]  exc;
        logic [15:0] word, status;
        logic        access, flush, silent;
        len    = r.frame_length;
        wb     = r.word_b;
        nc     = r.word_c[15:8];
        wd     = r.word_d;
        n10    = r.byte_ten;
        rlen   = len;
        exc    = EX_NONE;
        word   = '0;
        status = '0;
        access = 1'b0;
        flush  = 1'b0;
        silent = 1'b0;
        res    = '0;
        res.reply_kind = RK_NONE;
        res.outcome    = OC_OTHER;

        // runt or oversized frames are dropped before anything is counted
        if (len < 2 || len > FRAME_BYTES)
            return;
        diag_count[IX_BUS_MSG] += 16'd1;
        if (r.unit_id != slave_addr)
            return;
        diag_count[IX_SLAVE_MSG] += 16'd1;

        // listen-only: only a well-formed restart gets through
        if (listen_mode && (r.function_code != FC_DIAGNOSTIC || len < 6
                            || r.word_a != SF_RESTART)) begin
            diag_count[IX_NO_RESP] += 16'd1;
            res.outcome = OC_SILENT;
            return;
        end

        case (r.function_code)
            FC_READ_COILS, FC_READ_INPUTS: begin
                rlen = (wb + 7) / 8 + 3;
                if (len != 6 || wb == 0 || wb > MAX_READ_BITS || rlen + 2 > FRAME_BYTES)
                    exc = EX_ILLEGAL_VALUE;
                else
                    access = 1'b1;
            end
            FC_READ_HOLDING, FC_READ_INPUT_REGS: begin
                rlen = wb * 2 + 3;
                if (len != 6 || wb == 0 || wb > MAX_READ_REGS || rlen + 2 > FRAME_BYTES)
                    exc = EX_ILLEGAL_VALUE;
                else
                    access = 1'b1;
            end
            FC_WRITE_COIL: begin
                rlen = 6;
                if (len != 6 || (wb != 0 && wb != COIL_ON))
                    exc = EX_ILLEGAL_VALUE;
                else
                    access = 1'b1;
            end
            FC_WRITE_REG: begin
                rlen = 6;
                if (len != 6)
                    exc = EX_ILLEGAL_VALUE;
                else
                    access = 1'b1;
            end
            FC_READ_EXC_STATUS: begin
                rlen = 3;
                if (len != 2)
                    exc = EX_ILLEGAL_VALUE;
                else
                    access = 1'b1;
            end
            FC_DIAGNOSTIC: begin
                if (len < 6) begin
                    exc = EX_ILLEGAL_VALUE;
                end else if (r.word_a == SF_RESTART) begin
                    // echo unless listen-only; the environment does the reset
                    if (!listen_mode) begin
                        res.reply_kind     = RK_NORMAL;
                        res.reply_length   = r.frame_length;
                        res.reply_function = FC_DIAGNOSTIC;
                    end
                    res.restart_request = 1'b1;
                    res.outcome         = OC_RESTART;
                    return;
                end else if (r.word_a == SF_RETURN_QUERY) begin
                end else if (r.word_a == SF_FORCE_LISTEN) begin
                    listen_mode = 1'b1;
                    silent      = 1'b1;
                end else if (r.word_a == SF_CLEAR_COUNTERS) begin
                    foreach (diag_count[i])
                        diag_count[i] = '0;
                end else if (r.word_a >= SF_FIRST_COUNT && r.word_a <= SF_LAST_COUNT) begin
                    word = diag_count[r.word_a - SF_CLEAR_COUNTERS];
                end else if (r.word_a == SF_CLEAR_OVERRUN) begin
                    diag_count[IX_OVERRUN] = '0;
                    flush = 1'b1;
                end else begin
                    exc = EX_ILLEGAL_FUNCTION;
                end
            end
            FC_EVENT_COUNTER: begin
                rlen = 6;
                if (len != 2) begin
                    exc = EX_ILLEGAL_VALUE;
                end else begin
                    status = r.store_busy ? STATUS_BUSY : 16'h0000;
                    diag_count[IX_FC11] += 16'd1;
                    word = diag_count[IX_SLAVE_MSG] - diag_count[IX_EXCEPTION]
                           - diag_count[IX_NO_RESP] - diag_count[IX_FC11];
                end
            end
            FC_WRITE_COILS: begin
                rlen = 6;
                if (len < 8 || wb == 0 || wb > MAX_WRITE_BITS || nc != (wb + 7) / 8
                    || len != nc + 7)
                    exc = EX_ILLEGAL_VALUE;
                else
                    access = 1'b1;
            end
            FC_WRITE_REGS: begin
                rlen = 6;
                if (len < 9 || wb == 0 || wb > MAX_WRITE_REGS || nc != wb * 2
                    || len != nc + 7)
                    exc = EX_ILLEGAL_VALUE;
                else
                    access = 1'b1;
            end
            FC_READ_WRITE_REGS: begin
                rlen = wb * 2 + 3;
                if (len < 13 || wb == 0 || wb > MAX_RW_READ || wd == 0 || wd > MAX_RW_WRITE
                    || n10 != wd * 2 || len != n10 + 11 || rlen + 2 > FRAME_BYTES)
                    exc = EX_ILLEGAL_VALUE;
                else
                    access = 1'b1;
            end
            default: exc = EX_ILLEGAL_FUNCTION;
        endcase

        // the store's verdict overrides a validated access
        if (access && r.store_status != EX_NONE)
            exc = r.store_status;
        res.store_access = access;

        if (silent) begin
            diag_count[IX_NO_RESP] += 16'd1;
            res.outcome = OC_SILENT;
        end else if (exc != EX_NONE) begin
            diag_count[IX_EXCEPTION] += 16'd1;
            if (exc == EX_NAK)
                diag_count[IX_NAK] += 16'd1;
            else if (exc == EX_SLAVE_BUSY)
                diag_count[IX_BUSY] += 16'd1;
            res.reply_kind     = RK_EXCEPTION;
            res.reply_length   = 8'd3;
            res.reply_function = r.function_code + EXC_FLAG;
            res.exception_code = exc;
            res.outcome        = OC_EXCEPTION;
        end else begin
            res.reply_kind      = RK_NORMAL;
            res.reply_length    = rlen[7:0];
            res.reply_function  = r.function_code;
            res.reply_word      = word;
            res.status_word     = status;
            res.flush_request   = flush;
            res.outcome         = OC_DONE;
        end
    endtask

    function automatic t_bench_req frame(
        input logic [7:0]  len,
        input logic [7:0]  uid,
        input logic [7:0]  fc,
        input logic [15:0] wa,
        input logic [15:0] wb,
        input logic [15:0] wc,
        input logic [15:0] wd,
        input logic [7:0]  b10,
        input logic        busy,
        input logic [7:0]  st
    );
        t_bench_req r;
        r.frame_length  = len;
        r.unit_id       = uid;
        r.function_code = fc;
        r.word_a        = wa;
        r.word_b        = wb;
        r.word_c        = wc;
        r.word_d        = wd;
        r.byte_ten      = b10;
        r.store_busy    = busy;
        r.store_status  = st;
        return r;
    endfunction

    // mostly well-formed requests with random content, some broken, some noise
    function automatic t_bench_req random_request(input bit allow_listen);
        t_bench_req r;
        r.frame_length  = $urandom;
        r.unit_id       = $urandom;
        r.function_code = $urandom;
        r.word_a        = $urandom;
        r.word_b        = $urandom;
        r.word_c        = $urandom;
        r.word_d        = $urandom;
        r.byte_ten      = $urandom;
        r.store_busy    = $urandom_range(0, 1);
        r.store_status  = $urandom;
        if ($urandom_range(0, 3) != 0)
            r.store_status = EX_NONE;
        if ($urandom_range(0, 19) >= 3) begin
            if ($urandom_range(0, 15) != 0)
                r.unit_id = slave_addr;
            case ($urandom_range(0, 9))
                0: begin
                    r.function_code = $urandom_range(0, 1) ? FC_READ_COILS : FC_READ_INPUTS;
                    r.frame_length  = 8'd6;
                    r.word_b        = $urandom_range(1, 472);
                end
                1: begin
                    r.function_code = $urandom_range(0, 1) ? FC_READ_HOLDING
                                                           : FC_READ_INPUT_REGS;
                    r.frame_length  = 8'd6;
                    r.word_b        = $urandom_range(1, 29);
                end
                2: begin
                    r.function_code = FC_WRITE_COIL;
                    r.frame_length  = 8'd6;
                    r.word_b        = $urandom_range(0, 1) ? COIL_ON : 16'h0000;
                end
                3: begin
                    r.function_code = FC_WRITE_REG;
                    r.frame_length  = 8'd6;
                end
                4: begin
                    r.function_code = FC_READ_EXC_STATUS;
                    r.frame_length  = 8'd2;
                end
                5: begin
                    r.function_code = FC_DIAGNOSTIC;
                    r.frame_length  = 8'd6;
                    case ($urandom_range(0, 5))
                        0: r.word_a = SF_RETURN_QUERY;
                        1: r.word_a = SF_CLEAR_COUNTERS;
                        2: r.word_a = $urandom_range(SF_FIRST_COUNT, SF_LAST_COUNT);
                        3: r.word_a = SF_CLEAR_OVERRUN;
                        4: r.word_a = SF_RESTART;
                        default: r.word_a = $urandom_range(0, 31);
                    endcase
                end
                6: begin
                    r.function_code = FC_EVENT_COUNTER;
                    r.frame_length  = 8'd2;
                end
                7: begin
                    r.function_code   = FC_WRITE_COILS;
                    r.word_b          = $urandom_range(1, 456);
                    r.word_c[15:8]    = 8'((r.word_b + 16'd7) / 16'd8);
                    r.frame_length    = r.word_c[15:8] + 8'd7;
                end
                8: begin
                    r.function_code   = FC_WRITE_REGS;
                    r.word_b          = $urandom_range(1, 28);
                    r.word_c[15:8]    = 8'(r.word_b * 16'd2);
                    r.frame_length    = r.word_c[15:8] + 8'd7;
                end
                default: begin
                    r.function_code   = FC_READ_WRITE_REGS;
                    r.word_b          = $urandom_range(1, 29);
                    r.word_d          = $urandom_range(1, 26);
                    r.byte_ten        = 8'(r.word_d * 16'd2);
                    r.frame_length    = r.byte_ten + 8'd11;
                end
            endcase
            // break one rule now and then
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 4))
                    0: r.frame_length = $urandom_range(0, 1) ? r.frame_length + 8'd1
                                                             : r.frame_length - 8'd1;
                    1: r.word_b = $urandom;
                    2: r.word_b = '0;
                    3: r.word_c[15:8] = $urandom;
                    default: r.byte_ten = $urandom;
                endcase
            end
        end
        // listen-only sticks until reset, so it is kept for the last phase
        if (!allow_listen && r.function_code == FC_DIAGNOSTIC && r.word_a == SF_FORCE_LISTEN)
            r.word_a = SF_RETURN_QUERY;
        return r;
    endfunction

    // offer one request, hold it until taken, then queue its predicted reply
    task automatic send_request(input t_bench_req r);
        t_result res;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_req_valid     <= 1'b1;
        i_frame_length  <= r.frame_length;
        i_unit_id       <= r.unit_id;
        i_function_code <= r.function_code;
        i_word_a        <= r.word_a;
        i_word_b        <= r.word_b;
        i_word_c        <= r.word_c;
        i_word_d        <= r.word_d;
        i_byte_ten      <= r.byte_ten;
        i_store_busy    <= r.store_busy;
        i_store_status  <= r.store_status;
        @(posedge i_clk);
        while (o_req_stall)
            @(posedge i_clk);
        predict_reply(r, res);
        pending_replies.push_back(res);
    endtask

    task automatic wait_replies_drained();
        i_req_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_slave_address(input logic [7:0] addr);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= addr;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (addr != 8'd0 && addr <= MAX_SLAVE_ADDR)
            slave_addr = addr;
    endtask

    // field extremes, every function code, subfunctions and the drop rules
    task automatic test_frame_checks();
        logic [7:0] me;
        me = slave_addr;
        send_idle_pct = 20;
        rsp_idle_pct  = 20;
        send_request(frame(8'd0, me, FC_READ_HOLDING, 0, 1, 0, 0, 0, 0, 0));
        send_request(frame(8'd1, me, FC_READ_HOLDING, 0, 1, 0, 0, 0, 0, 0));
        send_request(frame(8'd2, me, FC_READ_EXC_STATUS, 0, 0, 0, 0, 0, 0, 0));
        send_request(frame(8'(FRAME_BYTES), me, FC_WRITE_REG, 0, 0, 0, 0, 0, 0, 0));
        send_request(frame(8'(FRAME_BYTES + 1), me, FC_WRITE_REG, 0, 0, 0, 0, 0, 0, 0));
        send_request(frame(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           8'hFF, 1'b1, 8'hFF));
        // someone else's address, then broadcast
        send_request(frame(8'd6, me + 8'd1, FC_READ_HOLDING, 0, 1, 0, 0, 0, 0, 0));
        send_request(frame(8'd6, 8'd0, FC_READ_HOLDING, 0, 1, 0, 0, 0, 0, 0));
        send_request(frame(8'd6, me, FC_READ_COILS, 16'hFFFF, 1, 0, 0, 0, 0, 0));
        send_request(frame(8'd6, me, FC_READ_INPUTS, 0, MAX_READ_BITS + 16'd1,
                           0, 0, 0, 0, 0));
        send_request(frame(8'd6, me, FC_READ_HOLDING, 0, 29, 0, 0, 0, 0, 0));
        // reply would not fit the buffer
        send_request(frame(8'd6, me, FC_READ_INPUT_REGS, 0, 30, 0, 0, 0, 0, 0));
        send_request(frame(8'd6, me, FC_WRITE_COIL, 0, COIL_ON, 0, 0, 0, 0, 0));
        // store exceptions: busy and nak
        send_request(frame(8'd6, me, FC_WRITE_REG, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0,
                           EX_SLAVE_BUSY));
        send_request(frame(8'd2, me, FC_READ_EXC_STATUS, 0, 0, 0, 0, 0, 0, EX_NAK));
        send_request(frame(8'd6, me, FC_DIAGNOSTIC, SF_RETURN_QUERY, 16'hFFFF, 0, 0, 0, 0, 0));
        send_request(frame(8'd6, me, FC_DIAGNOSTIC, SF_FIRST_COUNT, 0, 0, 0, 0, 0, 0));
        send_request(frame(8'd6, me, FC_DIAGNOSTIC, SF_CLEAR_OVERRUN, 0, 0, 0, 0, 0, 0));
        send_request(frame(8'd6, me, FC_DIAGNOSTIC, 16'h0002, 0, 0, 0, 0, 0, 0));
        send_request(frame(8'd6, me, FC_DIAGNOSTIC, SF_CLEAR_COUNTERS, 0, 0, 0, 0, 0, 0));
        send_request(frame(8'd5, me, FC_DIAGNOSTIC, SF_RETURN_QUERY, 0, 0, 0, 0, 0, 0));
        send_request(frame(8'd6, me, FC_DIAGNOSTIC, SF_RESTART, 16'hFF00, 0, 0, 0, 0, 0));
        send_request(frame(8'd2, me, FC_EVENT_COUNTER, 0, 0, 0, 0, 0, 1'b1, 0));
        send_request(frame(8'd8, me, FC_WRITE_COILS, 0, 8, 16'h0100, 0, 0, 0, 0));
        send_request(frame(8'd9, me, FC_WRITE_REGS, 0, 1, 16'h0200, 0, 0, 0, 8'hFF));
        send_request(frame(8'd13, me, FC_READ_WRITE_REGS, 0, 1, 0, 1, 8'd2, 0, 0));
        send_request(frame(8'd6, me, 8'h00, 0, 0, 0, 0, 0, 0, 0));
        send_request(frame(8'd6, me, 8'hFF, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // out-of-range address writes must leave the old address in place
    task automatic test_address_register();
        logic [7:0] bad_addr [3];
        bad_addr = '{8'd0, MAX_SLAVE_ADDR + 8'd1, 8'hFF};
        foreach (bad_addr[i]) begin
            wait_replies_drained();
            write_slave_address(bad_addr[i]);
            send_request(frame(8'd2, bad_addr[i], FC_READ_EXC_STATUS, 0, 0, 0, 0, 0, 0, 0));
            send_request(frame(8'd2, slave_addr, FC_READ_EXC_STATUS, 0, 0, 0, 0, 0, 0, 0));
        end
    endtask

    task automatic test_random_requests(input logic [7:0] addr, input int count,
                                        input int send_pct, input int rsp_pct);
        wait_replies_drained();
        write_slave_address(addr);
        send_idle_pct = send_pct;
        rsp_idle_pct  = rsp_pct;
        repeat (count)
            send_request(random_request(1'b0));
    endtask

    // receiver holds off long enough to back the block up into the request side
    task automatic test_reply_backpressure(input int count);
        send_idle_pct     = 0;
        rsp_idle_pct      = 0;
        long_hold_pending = 1'b1;
        repeat (count)
            send_request(random_request(1'b0));
        // sender pauses until every reply is back
        wait_replies_drained();
    endtask

    // force listen-only is sticky, so this runs last and with no idling
    task automatic test_listen_only(input int count);
        logic [7:0] me;
        me = slave_addr;
        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        send_request(frame(8'd6, me, FC_DIAGNOSTIC, SF_FORCE_LISTEN, 0, 0, 0, 0, 0, 0));
        send_request(frame(8'd6, me, FC_READ_HOLDING, 0, 1, 0, 0, 0, 0, 0));
        send_request(frame(8'd5, me, FC_DIAGNOSTIC, SF_RESTART, 0, 0, 0, 0, 0, 0));
        send_request(frame(8'd6, me, FC_DIAGNOSTIC, SF_RESTART, 0, 0, 0, 0, 0, 0));
        send_request(frame(8'd6, me + 8'd1, FC_DIAGNOSTIC, SF_RESTART, 0, 0, 0, 0, 0, 0));
        send_request(frame(8'd6, me, FC_DIAGNOSTIC, SF_FORCE_LISTEN, 0, 0, 0, 0, 0, 0));
        repeat (count)
            send_request(random_request(1'b1));
    endtask

    // reply side stall: random short bursts, or the one long hold when asked
    initial begin
        i_rsp_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_pending) begin
                i_rsp_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_pending = 1'b0;
                i_rsp_stall <= 1'b0;
            end else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
                i_rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_rsp_stall <= 1'b0;
            end
        end
    end

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("reply %0d: %s expected %h, got %h", replies_seen, name, exp_v, act_v);
        end
    endfunction

    // compare every accepted reply with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (pending_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("reply %0d: no request waiting, got outcome %0d",
                             replies_seen, o_outcome);
            end else begin
                front_reply = pending_replies.pop_front();
                check_field("reply_kind", front_reply.reply_kind, o_reply_kind);
                check_field("reply_length", front_reply.reply_length, o_reply_length);
                check_field("reply_function", front_reply.reply_function, o_reply_function);
                check_field("exception_code", front_reply.exception_code, o_exception_code);
                check_field("reply_word", front_reply.reply_word, o_reply_word);
                check_field("status_word", front_reply.status_word, o_status_word);
                check_field("store_access", front_reply.store_access, o_store_access);
                check_field("restart_request", front_reply.restart_request, o_restart_request);
                check_field("flush_request", front_reply.flush_request, o_flush_request);
                check_field("outcome", front_reply.outcome, o_outcome);
            end
            replies_seen++;
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("** modbus_request_checker_top: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        i_req_valid     = 1'b0;
        i_frame_length  = '0;
        i_unit_id       = '0;
        i_function_code = '0;
        i_word_a        = '0;
        i_word_b        = '0;
        i_word_c        = '0;
        i_word_d        = '0;
        i_byte_ten      = '0;
        i_store_busy    = 1'b0;
        i_store_status  = '0;
        send_idle_pct   = 0;
        rsp_idle_pct    = 0;
        slave_addr      = RESET_SLAVE_ADDR;
        listen_mode     = 1'b0;
        foreach (diag_count[i])
            diag_count[i] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_frame_checks();
        test_address_register();
        test_random_requests(MAX_SLAVE_ADDR, 100, 30, 30);
        test_random_requests(8'($urandom_range(2, 246)), 100, 0, 50);
        test_reply_backpressure(40);
        test_random_requests(RESET_SLAVE_ADDR, 90, 50, 0);
        test_listen_only(40);

        wait_replies_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("** modbus_request_checker_top: PASSED **");
        else
            $display("** modbus_request_checker_top: FAILED **");
        $finish;
    end

endmodule
